// File: hw/rtl/crsc_pkg.sv
// Shared types and constants for the Collatz range step counter.
`timescale 1ns / 1ps
package crsc_pkg;

  // Result status codes.
  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StOverflow = 2'd1;
  localparam logic [1:0] StZero     = 2'd2;
  localparam logic [1:0] StLimit    = 2'd3;

  localparam int unsigned CountWidth = 7;
  localparam int unsigned StepWidth  = 16;
  localparam int unsigned HalfWidth  = 64;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_range;
    logic       load_value;
    logic       step;
    logic       emit;
    logic [1:0] emit_status;
  } crsc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic value_zero;
    logic value_one;
    logic value_odd;
    logic overflow;
    logic at_limit;
  } crsc_sts_t;

endpackage

// File: hw/rtl/crsc_ctrl.sv
// Controller state machine that sequences values and Collatz steps.
`timescale 1ns / 1ps
module crsc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  crsc_pkg::crsc_sts_t sts_i,
  output crsc_pkg::crsc_cmd_t cmd_o,
  output logic              busy_o
);
  import crsc_pkg::*;

  localparam logic [1:0] StateIdle = 2'd0;
  localparam logic [1:0] StateInit = 2'd1;
  localparam logic [1:0] StateRun  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StateIdle: begin
        if (start_i) begin
          cmd_o.load_range = 1'b1;
          state_d          = StateInit;
        end
      end
      StateInit: begin
        if (sts_i.count_zero) begin
          state_d = StateIdle;
        end else begin
          cmd_o.load_value = 1'b1;
          state_d          = StateRun;
        end
      end
      StateRun: begin
        // The order of these checks matches the value's status priority.
        priority if (sts_i.value_zero) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = StZero;
        end else if (sts_i.value_one) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = StDone;
        end else if (sts_i.at_limit) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = StLimit;
        end else if (sts_i.value_odd && sts_i.overflow) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = StOverflow;
        end else begin
          cmd_o.step = 1'b1;
        end
        if (cmd_o.emit) begin
          state_d = StateInit;
        end
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StateIdle);

endmodule

// File: hw/rtl/crsc_dp.sv
// Datapath: range value, iterated value, step counter and result registers.
`timescale 1ns / 1ps
module crsc_dp #(
  parameter int unsigned VALUE_WIDTH = 128,
  parameter int unsigned MAX_STEPS   = 65535,
  parameter int unsigned MAX_RANGE   = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crsc_pkg::crsc_cmd_t  cmd_i,
  output crsc_pkg::crsc_sts_t  sts_o,
  input  logic [63:0]          start_low_i,
  input  logic [63:0]          start_high_i,
  input  logic [6:0]           value_count_i,
  output logic [15:0]          step_length_o,
  output logic [1:0]           status_o,
  output logic                 last_of_range_o,
  output logic                 result_valid_o
);
  import crsc_pkg::*;

  localparam logic [CountWidth-1:0] MaxRange = CountWidth'(MAX_RANGE);
  localparam logic [StepWidth-1:0]  MaxSteps = StepWidth'(MAX_STEPS);

  logic [2*HalfWidth-1:0]  start_full;
  logic [CountWidth-1:0]   count_clamped;
  logic [VALUE_WIDTH-1:0]  range_q;
  logic [VALUE_WIDTH-1:0]  value_q, value_d;
  logic [VALUE_WIDTH+1:0]  triple_sum;
  logic [StepWidth-1:0]    steps_q;
  logic [CountWidth-1:0]   left_q;
  logic [StepWidth-1:0]    length_q;
  logic [1:0]              status_q;
  logic                    last_q;
  logic                    valid_q;

  assign start_full    = {start_high_i, start_low_i};
  assign count_clamped = (value_count_i > MaxRange) ? MaxRange : value_count_i;

  // 3n+1 formed as 2n + n + 1 with two guard bits to catch overflow.
  assign triple_sum = {1'b0, value_q, 1'b0} + {2'b00, value_q} + (VALUE_WIDTH + 2)'(1);
  assign value_d    = value_q[0] ? triple_sum[VALUE_WIDTH-1:0]
                                 : {1'b0, value_q[VALUE_WIDTH-1:1]};

  always_comb begin
    sts_o            = '0;
    sts_o.count_zero = (left_q == '0);
    sts_o.value_zero = (value_q == '0);
    sts_o.value_one  = (value_q == VALUE_WIDTH'(1));
    sts_o.value_odd  = value_q[0];
    sts_o.overflow   = |triple_sum[VALUE_WIDTH+1:VALUE_WIDTH];
    sts_o.at_limit   = (steps_q >= MaxSteps);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cmd_i.load_range) begin
        left_q <= count_clamped;
      end else if (cmd_i.emit) begin
        left_q <= left_q - CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_range) begin
      range_q <= start_full[VALUE_WIDTH-1:0];
    end else if (cmd_i.emit) begin
      range_q <= range_q + VALUE_WIDTH'(1);
    end
    if (cmd_i.load_value) begin
      value_q <= range_q;
      steps_q <= '0;
    end else if (cmd_i.step) begin
      value_q <= value_d;
      steps_q <= steps_q + StepWidth'(1);
    end
    if (cmd_i.emit) begin
      length_q <= (cmd_i.emit_status == StDone) ? steps_q : '0;
      status_q <= cmd_i.emit_status;
      last_q   <= (left_q == CountWidth'(1));
    end
  end

  assign step_length_o   = length_q;
  assign status_o        = status_q;
  assign last_of_range_o = last_q;
  assign result_valid_o  = valid_q;

endmodule

// File: hw/rtl/collatz_range_step_counter.sv
// Top level of the Collatz range step counter.
//
//   channel   direction  handshake                 payload
//   command   in         start_i high, busy_o low  start_low_i, start_high_i, value_count_i
//   result    out        result_valid_o strobe     step_length_o, status_o, last_of_range_o
//
// Each value of the range is loaded, stepped until it stops and then reported; each
// step is one pass through the shared 3n+1 adder.
// A count of zero keeps busy_o high for one cycle after the transfer and gives no result.
// Reset clears the controller and the result strobe; the receiver cannot stall.
`timescale 1ns / 1ps
module collatz_range_step_counter #(
  parameter int unsigned VALUE_WIDTH = 128,
  parameter int unsigned MAX_STEPS   = 65535,
  parameter int unsigned MAX_RANGE   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] start_low_i,
  input  logic [63:0] start_high_i,
  input  logic [6:0]  value_count_i,
  output logic        result_valid_o,
  output logic [15:0] step_length_o,
  output logic [1:0]  status_o,
  output logic        last_of_range_o
);
  import crsc_pkg::*;

  crsc_cmd_t cmd;
  crsc_sts_t sts;

  crsc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  crsc_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_STEPS   (MAX_STEPS),
    .MAX_RANGE   (MAX_RANGE)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .start_low_i     (start_low_i),
    .start_high_i    (start_high_i),
    .value_count_i   (value_count_i),
    .step_length_o   (step_length_o),
    .status_o        (status_o),
    .last_of_range_o (last_of_range_o),
    .result_valid_o  (result_valid_o)
  );

  // A result transfer only happens while a range is in progress.
  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result strobe outside a busy range");

  // An accepted command with a nonzero count keeps the block busy.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && value_count_i != '0) |=> busy_o)
    else $error("block not busy after accepting a range");

  // Failed values always report a zero step length.
  a_zero_length_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o != StDone) |-> (step_length_o == '0))
    else $error("nonzero step length on a failed value");

endmodule

// File: sim/collatz_range_step_counter_test.sv
// Self-checking testbench for the Collatz range step counter.
`timescale 1ns / 1ps
module collatz_range_step_counter_test;
  import crsc_pkg::*;

  localparam int unsigned ValueWidth = 128;
  localparam int unsigned MaxSteps   = 65535;
  localparam int unsigned MaxRange   = 64;
  localparam int unsigned RandomRanges = 81;
  // One value may iterate for the whole step budget with no transfer at all.
  localparam int unsigned StallLimit = 4 * (MaxSteps + 16);
  localparam logic [63:0] Ones64 = {64{1'b1}};
  localparam logic [127:0] ValueMask = {128{1'b1}} >> (128 - ValueWidth);

  typedef struct packed {
    logic [15:0] steps;
    logic [1:0]  status;
    logic        last;
  } stop_time_t;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
    logic [6:0]  count;
    bit          known;
    stop_time_t  want;
  } range_row_t;

  typedef enum int {
    SmallStart, Word32Start, Word64Start, FullStart, TopStart, CarryStart
  } start_kind_e;

  localparam stop_time_t NoCheck = '0;
  localparam int unsigned NumDirected = 19;

  // Rows marked known carry the single result that they must produce, or none for a count of zero.
  range_row_t directed_rows [NumDirected] = '{
    '{64'd1, 64'd0, 7'd1, 1'b1, '{16'd0, StDone, 1'b1}},
    '{64'd0, 64'd0, 7'd1, 1'b1, '{16'd0, StZero, 1'b1}},
    '{64'd0, 64'd0, 7'd0, 1'b1, NoCheck},
    '{64'd2, 64'd0, 7'd1, 1'b1, '{16'd1, StDone, 1'b1}},
    '{64'd3, 64'd0, 7'd1, 1'b1, '{16'd7, StDone, 1'b1}},
    '{64'd27, 64'd0, 7'd1, 1'b0, NoCheck},
    '{64'd0, 64'h8000_0000_0000_0000, 7'd1, 1'b1, '{16'd127, StDone, 1'b1}},
    '{Ones64, Ones64, 7'd1, 1'b1, '{16'd0, StOverflow, 1'b1}},
    '{64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 7'd1, 1'b1,
      '{16'd0, StOverflow, 1'b1}},
    '{64'h5555_5555_5555_5554, 64'h5555_5555_5555_5555, 7'd2, 1'b0, NoCheck},
    '{Ones64, Ones64, 7'd3, 1'b0, NoCheck},
    '{Ones64, 64'd0, 7'd2, 1'b0, NoCheck},
    '{64'd1, 64'd0, 7'd64, 1'b0, NoCheck},
    '{64'd5, 64'd0, 7'd127, 1'b0, NoCheck},
    '{64'd27, 64'd0, 7'd65, 1'b0, NoCheck},
    '{Ones64 - 64'd31, Ones64, 7'd64, 1'b0, NoCheck},
    '{64'd0, 64'd0, 7'd64, 1'b0, NoCheck},
    '{Ones64, Ones64, 7'd0, 1'b1, NoCheck},
    '{64'h0123_4567_89AB_CDEF, 64'd0, 7'd4, 1'b0, NoCheck}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [63:0] start_low_i;
  logic [63:0] start_high_i;
  logic [6:0]  value_count_i;
  logic        result_valid_o;
  logic [15:0] step_length_o;
  logic [1:0]  status_o;
  logic        last_of_range_o;

  stop_time_t  pending_stop_times [$];
  int unsigned ranges_sent;
  int unsigned results_seen;
  int unsigned mismatch_count;
  int unsigned stall_cycles;
  int unsigned no_idle_left;
  int unsigned status_seen [4];

  collatz_range_step_counter #(
    .VALUE_WIDTH(ValueWidth),
    .MAX_STEPS  (MaxSteps),
    .MAX_RANGE  (MaxRange)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .start_low_i    (start_low_i),
    .start_high_i   (start_high_i),
    .value_count_i  (value_count_i),
    .result_valid_o (result_valid_o),
    .step_length_o  (step_length_o),
    .status_o       (status_o),
    .last_of_range_o(last_of_range_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Iterates one start value the way the block does and returns its result.
  function automatic stop_time_t trace_stopping_time(logic [127:0] first);
    logic [129:0] n;
    int unsigned  steps;
    stop_time_t   r;
    r = '0;
    if (first == '0) begin
      r.status = StZero;
      return r;
    end
    n = {2'b00, first};
    steps = 0;
    while (n != 130'd1) begin
      if (steps >= MaxSteps) begin
        r.status = StLimit;
        return r;
      end
      if (!n[0]) begin
        n = n >> 1;
      end else begin
        n = n + (n << 1) + 130'd1;
        if ((n >> ValueWidth) != 0) begin
          r.status = StOverflow;
          return r;
        end
      end
      steps++;
    end
    r.steps = steps[15:0];
    r.status = StDone;
    return r;
  endfunction

  function automatic void predict_range(logic [127:0] first, logic [6:0] cnt);
    logic [127:0] v;
    int unsigned  total;
    stop_time_t   r;
    total = (cnt > MaxRange) ? MaxRange : cnt;
    v = first & ValueMask;
    for (int i = 0; i < total; i++) begin
      r = trace_stopping_time(v);
      r.last = (i == total - 1);
      pending_stop_times.push_back(r);
      v = (v + 128'd1) & ValueMask;
    end
  endfunction

  task automatic send_range(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [6:0] cnt, input bit known,
                            input stop_time_t want);
    int unsigned gap;
    gap = (no_idle_left != 0) ? 0 : $urandom_range(0, 8);
    if (no_idle_left != 0) no_idle_left--;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    start_low_i   <= lo;
    start_high_i  <= hi;
    value_count_i <= cnt;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (known) begin
      if (cnt != 0) pending_stop_times.push_back(want);
    end else begin
      predict_range({hi, lo}, cnt);
    end
    ranges_sent++;
  endtask

  task automatic send_random_range();
    start_kind_e kind;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [6:0]  cnt;
    int unsigned pick;
    kind = start_kind_e'($urandom_range(0, 5));
    hi = '0;
    case (kind)
      SmallStart: begin
        lo = 64'($urandom_range(0, 2000));
      end
      Word32Start: begin
        lo = 64'($urandom);
      end
      Word64Start: begin
        lo = {$urandom, $urandom};
      end
      FullStart: begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end
      TopStart: begin
        lo = Ones64 - 64'($urandom_range(0, 100));
        hi = Ones64;
      end
      default: begin
        lo = Ones64 - 64'($urandom_range(0, 10));
        hi = 64'($urandom_range(0, 3));
      end
    endcase
    // Long ranges only with short trajectories, to keep the run short.
    if (kind == SmallStart || kind == Word32Start) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) cnt = 7'($urandom_range(0, 8));
      else if (pick < 9) cnt = 7'($urandom_range(9, 64));
      else cnt = 7'($urandom_range(65, 127));
    end else begin
      cnt = 7'($urandom_range(0, 6));
    end
    send_range(lo, hi, cnt, 1'b0, NoCheck);
  endtask

  always @(posedge clk_i) begin
    stop_time_t want;
    if (rst_ni && result_valid_o) begin
      stall_cycles = 0;
      if (pending_stop_times.size() == 0) begin
        $display("%0t: unexpected result: steps %0d status %0d last %0d",
                 $time, step_length_o, status_o, last_of_range_o);
        mismatch_count++;
      end else begin
        want = pending_stop_times.pop_front();
        results_seen++;
        status_seen[want.status]++;
        if (step_length_o !== want.steps) begin
          $display("%0t: step_length expected %0d, got %0d",
                   $time, want.steps, step_length_o);
          mismatch_count++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, status_o);
          mismatch_count++;
        end
        if (last_of_range_o !== want.last) begin
          $display("%0t: last_of_range expected %0d, got %0d",
                   $time, want.last, last_of_range_o);
          mismatch_count++;
        end
      end
    end else if (start_i && !busy_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("collatz_range_step_counter test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    start_low_i   = '0;
    start_high_i  = '0;
    value_count_i = '0;
    ranges_sent    = 0;
    results_seen   = 0;
    mismatch_count = 0;
    stall_cycles   = 0;
    no_idle_left   = 0;
    status_seen    = '{default: 0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_range(directed_rows[i].lo, directed_rows[i].hi, directed_rows[i].count,
                 directed_rows[i].known, directed_rows[i].want);
    end
    for (int n = 0; n < RandomRanges; n++) begin
      // Now and then issue a run of back-to-back commands.
      if (no_idle_left == 0 && $urandom_range(0, 15) == 0) no_idle_left = 8;
      send_random_range();
    end
    start_i <= 1'b0;

    while (pending_stop_times.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Sent %0d ranges (%0d directed), checked %0d results.",
             ranges_sent, NumDirected, results_seen);
    $display("Reached one %0d, overflowed %0d, zero start %0d, step limit %0d.",
             status_seen[StDone], status_seen[StOverflow], status_seen[StZero],
             status_seen[StLimit]);
    if (mismatch_count == 0) begin
      $display("collatz_range_step_counter test passed");
    end else begin
      $display("collatz_range_step_counter test failed");
    end
    $finish;
  end

endmodule
